>>> rtl/reol_pkg.sv
// ----------------------------------------------------------------------------
// reol_pkg
// Shared types and constants for the ring entry offset lookup unit.
// ----------------------------------------------------------------------------
package reol_pkg;

    localparam int HANDLE_W   = 32;
    localparam int SIZE_IN_W  = 16;
    localparam int OFFSET_W   = 20;
    localparam int SLOT_OUT_W = 4;
    localparam int BYTE_W     = 16;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FIND = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [HANDLE_W-1:0]   found_handle;
        logic [BYTE_W-1:0]     byte_in_entry;
    } t_result;

endpackage

>>> rtl/reol_store.sv
// ----------------------------------------------------------------------------
// reol_store
// Entry memories: handle and size arrays, one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module reol_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int SW    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [reol_pkg::HANDLE_W-1:0] i_wdata_handle,
    input  logic [SW-1:0]                i_wdata_size,
    input  logic [AW-1:0]                i_raddr,
    output logic [reol_pkg::HANDLE_W-1:0] o_rd_handle,
    output logic [SW-1:0]                o_rd_size
);
    import reol_pkg::*;

    logic [HANDLE_W-1:0] r_handle_mem [DEPTH];
    logic [SW-1:0]       r_size_mem   [DEPTH];
    logic [HANDLE_W-1:0] r_rd_handle;
    logic [SW-1:0]       r_rd_size;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_handle_mem[i_waddr] <= i_wdata_handle;
            r_size_mem[i_waddr]   <= i_wdata_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_handle <= r_handle_mem[i_raddr];
        r_rd_size   <= r_size_mem[i_raddr];
    end

    assign o_rd_handle = r_rd_handle;
    assign o_rd_size   = r_rd_size;

endmodule

>>> rtl/reol_ctrl.sv
// ----------------------------------------------------------------------------
// reol_ctrl
// Ring indices and lookup sequencer: stores added entries and walks the ring
// one entry per cycle, accumulating sizes until the offset is covered.
// ----------------------------------------------------------------------------
module reol_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int SW    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [reol_pkg::HANDLE_W-1:0]  i_entry_handle,
    input  logic [reol_pkg::SIZE_IN_W-1:0] i_entry_size,
    input  logic [reol_pkg::OFFSET_W-1:0]  i_char_offset,
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output logic [reol_pkg::HANDLE_W-1:0]  o_wdata_handle,
    output logic [SW-1:0]                 o_wdata_size,
    output logic [AW-1:0]                 o_raddr,
    input  logic [reol_pkg::HANDLE_W-1:0]  i_rd_handle,
    input  logic [SW-1:0]                 i_rd_size,
    output logic                          o_res_valid,
    output reol_pkg::t_result             o_res,
    input  logic                          i_res_take
);
    import reol_pkg::*;

    localparam int CW    = SW + AW + 1;
    localparam int CMP_W = ((CW > OFFSET_W) ? CW : OFFSET_W) + 1;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_wr_idx, n_wr_idx;
    logic [AW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_full, n_full;
    logic [AW-1:0]       r_slot, n_slot;
    logic [CW-1:0]       r_count, n_count;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    t_result             r_res, n_res;

    logic [AW-1:0]       slot_next;
    logic [AW-1:0]       wr_next;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    sum_ext;
    logic [CMP_W-1:0]    off_ext;
    logic [CMP_W-1:0]    diff_ext;
    logic [AW+3:0]       slot_wide;
    logic                hit_now;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] idx);
        f_next = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign slot_next = f_next(r_slot);
    assign wr_next   = f_next(r_wr_idx);
    assign cnt_ext   = CMP_W'(r_count);
    assign sum_ext   = cnt_ext + CMP_W'(i_rd_size);
    assign off_ext   = CMP_W'(r_offset);
    assign diff_ext  = off_ext - cnt_ext;
    assign slot_wide = {4'b0000, r_slot};
    assign hit_now   = (i_rd_size != '0) && (off_ext < sum_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_full   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_full   <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_count  <= n_count;
        r_offset <= n_offset;
        r_res    <= n_res;
    end

    always_comb begin
        n_state        = r_state;
        n_wr_idx       = r_wr_idx;
        n_rd_idx       = r_rd_idx;
        n_full         = r_full;
        n_slot         = r_slot;
        n_count        = r_count;
        n_offset       = r_offset;
        n_res          = r_res;
        o_we           = 1'b0;
        o_waddr        = r_wr_idx;
        o_wdata_handle = i_entry_handle;
        o_wdata_size   = i_entry_size[SW-1:0];
        o_raddr        = slot_next;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res = '0;
                    if (i_action == ACT_ADD) begin
                        o_we     = 1'b1;
                        n_wr_idx = wr_next;
                        if (r_full) begin
                            n_rd_idx = wr_next;
                        end else if (wr_next == r_rd_idx) begin
                            n_full = 1'b1;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_offset = i_char_offset;
                        if (r_wr_idx == r_rd_idx && !r_full) begin
                            n_state = S_DONE;
                        end else begin
                            o_raddr = r_rd_idx;
                            n_slot  = r_rd_idx;
                            n_count = '0;
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                if (hit_now) begin
                    n_res.hit           = 1'b1;
                    n_res.slot_index    = slot_wide[SLOT_OUT_W-1:0];
                    n_res.found_handle  = i_rd_handle;
                    n_res.byte_in_entry = diff_ext[BYTE_W-1:0];
                    n_state             = S_DONE;
                end else begin
                    n_count = sum_ext[CW-1:0];
                    if (slot_next == r_wr_idx) begin
                        n_state = S_DONE;
                    end else begin
                        n_slot = slot_next;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

>>> rtl/ring_entry_offset_lookup_unit.sv
// ----------------------------------------------------------------------------
// ring_entry_offset_lookup_unit
// Circular buffer of handle/size entries with overwrite, and byte offset
// lookup over the concatenated entries.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one beat is an add (i_action = 0) or a
// find (i_action = 1). Output channel (o_valid / i_stall): one result beat
// per input beat, in order; an add returns an all-zero result.
// An add does one memory write, then the result moves to the output
// register. A find on an empty ring goes straight to its result; otherwise
// it visits 1 to DEPTH entries: the walk reads one entry per cycle from the
// entry memory's single read port and accumulates sizes, stopping at the
// entry that covers the offset or at the newest entry.
// One beat is in the sequencer at a time: the next input beat is accepted
// once the sequencer hands its result on.
// A result waits in the output register while i_stall is high; the next
// input beat is accepted meanwhile, and its result waits in the sequencer.
// Reset empties the ring (indices and full flag cleared) and drops any
// pending result; entry memories keep their contents and need no clearing.
// ----------------------------------------------------------------------------
module ring_entry_offset_lookup_unit #(
    parameter int DEPTH     = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [reol_pkg::HANDLE_W-1:0]  i_entry_handle,
    input  logic [reol_pkg::SIZE_IN_W-1:0] i_entry_size,
    input  logic [reol_pkg::OFFSET_W-1:0]  i_char_offset,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic [reol_pkg::SLOT_OUT_W-1:0] o_slot_index,
    output logic [reol_pkg::HANDLE_W-1:0]  o_found_handle,
    output logic [reol_pkg::BYTE_W-1:0]    o_byte_in_entry
);
    import reol_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = (SIZE_BITS < SIZE_IN_W) ? SIZE_BITS : SIZE_IN_W;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [HANDLE_W-1:0] wdata_handle;
    logic [SW-1:0]       wdata_size;
    logic [AW-1:0]       raddr;
    logic [HANDLE_W-1:0] rd_handle;
    logic [SW-1:0]       rd_size;
    logic                res_valid;
    t_result             res;
    logic                res_take;

    logic                r_out_valid;
    t_result             r_out;

    reol_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .SW    (SW)
    ) u_store (
        .i_clk          (i_clk),
        .i_we           (we),
        .i_waddr        (waddr),
        .i_wdata_handle (wdata_handle),
        .i_wdata_size   (wdata_size),
        .i_raddr        (raddr),
        .o_rd_handle    (rd_handle),
        .o_rd_size      (rd_size)
    );

    reol_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .SW    (SW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_entry_handle (i_entry_handle),
        .i_entry_size   (i_entry_size),
        .i_char_offset  (i_char_offset),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata_handle (wdata_handle),
        .o_wdata_size   (wdata_size),
        .o_raddr        (raddr),
        .i_rd_handle    (rd_handle),
        .i_rd_size      (rd_size),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_take     (res_take)
    );

    assign res_take = res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out.hit;
    assign o_slot_index    = r_out.slot_index;
    assign o_found_handle  = r_out.found_handle;
    assign o_byte_in_entry = r_out.byte_in_entry;

endmodule
